// ===== hw/rtl/sha1bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types and constants of the hasher modules.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [159:0] words;
    logic         too_long;
  } digest_t;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [63:0] CountMax  = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam logic [5:0]  LenPos    = 6'd56;
  localparam logic [5:0]  LastPos   = 6'd63;
  localparam logic [6:0]  LastRound = 7'd79;
  localparam logic [2:0]  LastWord  = 3'd4;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/sha1bsh_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher front end
// Two-entry input queue that drops items carrying neither a byte nor an end.
// ----------------------------------------------------------------------------
module sha1bsh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  sha1bsh_pkg::item_t  item_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output sha1bsh_pkg::item_t  item_o
);
  import sha1bsh_pkg::*;

  item_t      mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       wr_en;
  logic       rd_en;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign wr_en        = push_i && !full_o && (item_i.has_byte || item_i.end_of_message);
  assign rd_en        = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_q <= ~wr_q;
      end
      if (rd_en) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("Input queue count out of range.");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("Input queue pointers disagree with count.");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("Input queue lost a transaction.");

endmodule

// ===== hw/rtl/sha1bsh_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher core
// Block buffer, padding sequencer and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sha1bsh_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  sha1bsh_pkg::item_t   item_i,
  output logic                 dig_valid_o,
  input  logic                 dig_ready_i,
  output sha1bsh_pkg::digest_t dig_o
);
  import sha1bsh_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]   state_q;
  logic [2:0]   state_d;
  logic [511:0] blk_q;
  logic [5:0]   pos_q;
  logic [63:0]  bitcnt_q;
  logic [63:0]  len_q;
  logic         ovf_q;
  logic         padreq_q;
  logic         first_q;
  logic         lenmode_q;
  logic         fin_q;
  logic [6:0]   round_q;
  logic [31:0]  h_q [5];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;

  logic         push_en;
  logic [7:0]   push_byte;
  logic         len_byte;
  logic [63:0]  bitcnt_nx;
  logic [31:0]  w_new;
  logic [31:0]  t_sum;
  logic         take;
  logic         emit;

  assign item_ready_o = (state_q == S_LOAD);
  assign take         = item_valid_i && item_ready_o;
  assign dig_valid_o  = (state_q == S_EMIT);
  assign emit         = dig_valid_o && dig_ready_i;
  assign dig_o.words  = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
  assign dig_o.too_long = ovf_q;

  assign len_byte  = !first_q && (lenmode_q || pos_q == LenPos);
  assign bitcnt_nx = bitcnt_q + 64'd8;

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    if (state_q == S_LOAD) begin
      push_en   = take && item_i.has_byte;
      push_byte = item_i.data_byte;
    end else if (state_q == S_PAD) begin
      push_en = 1'b1;
      if (first_q) begin
        push_byte = PadByte;
      end else if (len_byte) begin
        push_byte = len_q[63:56];
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  assign w_new = {blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480]}
                 << 1 | {31'd0, (blk_q[95] ^ blk_q[255] ^ blk_q[447] ^ blk_q[511])};
  assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
                 + round_k(round_q) + blk_q[511:480];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (take) begin
          if (item_i.has_byte && pos_q == LastPos) begin
            state_d = S_ROUND;
          end else if (item_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pos_q == LastPos) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_q == LastRound) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (fin_q) begin
          state_d = S_EMIT;
        end else if (padreq_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_EMIT: begin
        if (dig_ready_i) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      blk_q <= {blk_q[503:0], push_byte};
    end else if (state_q == S_ROUND) begin
      blk_q <= {blk_q[479:0], w_new};
    end
    if (state_q == S_ROUND) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      pos_q     <= 6'd0;
      bitcnt_q  <= 64'd0;
      len_q     <= 64'd0;
      ovf_q     <= 1'b0;
      padreq_q  <= 1'b0;
      first_q   <= 1'b0;
      lenmode_q <= 1'b0;
      fin_q     <= 1'b0;
      round_q   <= 7'd0;
      h_q[0]    <= H0;
      h_q[1]    <= H1;
      h_q[2]    <= H2;
      h_q[3]    <= H3;
      h_q[4]    <= H4;
    end else begin
      state_q <= state_d;
      if (push_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (take && item_i.has_byte) begin
        bitcnt_q <= bitcnt_nx;
        if (bitcnt_q >= CountMax) begin
          ovf_q <= 1'b1;
        end
      end
      if (take && item_i.end_of_message) begin
        padreq_q <= 1'b1;
        first_q  <= 1'b1;
        len_q    <= item_i.has_byte ? bitcnt_nx : bitcnt_q;
      end
      if (state_q == S_PAD) begin
        first_q <= 1'b0;
        if (len_byte) begin
          lenmode_q <= 1'b1;
          len_q     <= {len_q[55:0], 8'h00};
          if (pos_q == LastPos) begin
            padreq_q <= 1'b0;
            fin_q    <= 1'b1;
          end
        end
      end
      if (state_q == S_ROUND) begin
        round_q <= round_q + 7'd1;
      end else begin
        round_q <= 7'd0;
      end
      if (state_q == S_ADD) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (emit) begin
        h_q[0]    <= H0;
        h_q[1]    <= H1;
        h_q[2]    <= H2;
        h_q[3]    <= H3;
        h_q[4]    <= H4;
        bitcnt_q  <= 64'd0;
        ovf_q     <= 1'b0;
        fin_q     <= 1'b0;
        lenmode_q <= 1'b0;
      end
    end
  end

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && round_q == LastRound) |=> (state_q == S_ADD))
    else $error("Compression did not end after the last round.");
  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (pos_q == 6'd0 && bitcnt_q == 64'd0 && !ovf_q && !padreq_q))
    else $error("State not cleared after a digest transaction.");
  a_fin_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !padreq_q) else $error("Finish and pad request both set.");
  a_pad_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pos_q == 6'd0))
    else $error("Digest offered with a partial block.");

endmodule

// ===== hw/rtl/sha1bsh_out.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher result stage
// Holds one digest and hands it out as five words, most significant first.
// ----------------------------------------------------------------------------
module sha1bsh_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 dig_valid_i,
  output logic                 dig_ready_o,
  input  sha1bsh_pkg::digest_t dig_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [31:0]          digest_word_o,
  output logic [2:0]           word_index_o,
  output logic                 last_word_o,
  output logic                 too_long_o
);
  import sha1bsh_pkg::*;

  logic [159:0] words_q;
  logic         too_long_q;
  logic [2:0]   idx_q;
  logic         busy_q;
  logic         take;

  assign dig_ready_o   = !busy_q;
  assign empty_o       = !busy_q;
  assign take          = pop_i && busy_q;
  assign digest_word_o = words_q[159:128];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LastWord);
  assign too_long_o    = too_long_q;

  always_ff @(posedge clk_i) begin
    if (dig_valid_i && dig_ready_o) begin
      words_q    <= dig_i.words;
      too_long_q <= dig_i.too_long;
    end else if (take) begin
      words_q <= {words_q[127:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      if (dig_valid_i && dig_ready_o) begin
        busy_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (take) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == LastWord) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= LastWord)) else $error("Word index out of range.");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && idx_q == LastWord) |=> !busy_q)
    else $error("Result stage held after the last word.");
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_valid_i && dig_ready_o) |=> (busy_q && idx_q == 3'd0))
    else $error("Digest load did not start at word zero.");

endmodule

// ===== hw/rtl/sha1_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a byte stream and returns each digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Bytes enter through a two-entry queue and move into the block buffer at one
// per cycle while the core is loading. Every full 64-byte block then passes
// through the single compression round unit (80 rounds and the chaining add),
// during which no bytes are taken. An end marker adds 9 to 72 padding bytes
// and one or two compressions, after which the five digest words are offered,
// word 0 first, one per pop transaction. The next message can start while
// the digest words are being drained.
module sha1_byte_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        too_long_o
);
  import sha1bsh_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  digest_t dig;
  logic    dig_valid;
  logic    dig_ready;

  assign in_item.data_byte      = data_byte_i;
  assign in_item.has_byte       = has_byte_i;
  assign in_item.end_of_message = end_of_message_i;

  sha1bsh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_ready_i (q_ready),
    .item_o       (q_item)
  );

  sha1bsh_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .dig_valid_o  (dig_valid),
    .dig_ready_i  (dig_ready),
    .dig_o        (dig)
  );

  sha1bsh_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dig_valid_i   (dig_valid),
    .dig_ready_o   (dig_ready),
    .dig_i         (dig),
    .empty_o       (empty),
    .pop_i         (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o),
    .too_long_o    (too_long_o)
  );

endmodule

// ===== dv/sha1_digest_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the byte and digest channels of the hasher. It keeps its own SHA-1
// state, works out the five digest words of every finished message and
// compares each popped word field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] digest_word_o,
  input  logic [2:0]  word_index_o,
  input  logic        last_word_o,
  input  logic        too_long_o,
  output int          fail_count,
  output int          pending,
  output int          words_checked
);
  import sha1bsh_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
    logic        too_long;
  } digest_word_t;

  localparam int ReportCap = 25;

  item_t        item_in;
  logic [31:0]  chain_h [5];
  logic [7:0]   blk_bytes [64];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_bit_total;
  logic         count_wrapped;
  digest_word_t digest_words_due [$];

  assign item_in = {data_byte_i, has_byte_i, end_of_message_i};

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= ReportCap) begin
      $display("[%0t] digest mismatch: %s", $time, msg);
    end
  endtask

  function automatic void clear_message();
    chain_h[0]    = H0;
    chain_h[1]    = H1;
    chain_h[2]    = H2;
    chain_h[3]    = H3;
    chain_h[4]    = H4;
    blk_fill      = '0;
    msg_bit_total = '0;
    count_wrapped = 1'b0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_bytes[blk_fill] = v;
    if (blk_fill == LastPos) begin
      blk_fill = '0;
      compress_block();
    end else begin
      blk_fill = blk_fill + 6'd1;
    end
  endfunction

  function automatic void take_item(input item_t it);
    logic [63:0]  msg_bits;
    digest_word_t dw;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      if (msg_bit_total >= CountMax) begin
        count_wrapped = 1'b1;
      end
      msg_bit_total = msg_bit_total + 64'd8;
    end
    if (it.end_of_message) begin
      msg_bits = msg_bit_total;
      absorb_byte(PadByte);
      if (blk_fill > LenPos) begin
        while (blk_fill != '0) absorb_byte(8'h00);
      end
      while (blk_fill < LenPos) absorb_byte(8'h00);
      for (int s = 7; s >= 0; s--) begin
        absorb_byte(msg_bits[8*s +: 8]);
      end
      for (int i = 0; i < 5; i++) begin
        dw.word     = chain_h[i];
        dw.index    = 3'(i);
        dw.last     = (3'(i) == LastWord);
        dw.too_long = count_wrapped;
        digest_words_due.insert(digest_words_due.size(), dw);
      end
      clear_message();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t due;
    if (!rst_ni) begin
      clear_message();
      digest_words_due.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (pop && !empty) begin
        words_checked++;
        if (digest_words_due.size() == 0) begin
          report_mismatch($sformatf("word %h index %0d arrived with nothing due",
                                    digest_word_o, word_index_o));
        end else begin
          due = digest_words_due.pop_front();
          if (digest_word_o !== due.word) begin
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      digest_word_o, due.word, due.index));
          end
          if (word_index_o !== due.index) begin
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      word_index_o, due.index));
          end
          if (last_word_o !== due.last) begin
            report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                      last_word_o, due.last, due.index));
          end
          if (too_long_o !== due.too_long) begin
            report_mismatch($sformatf("too_long %b, expected %b (index %0d)",
                                      too_long_o, due.too_long, due.index));
          end
        end
      end
      if (push && !full) begin
        take_item(item_in);
      end
    end
    pending = digest_words_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds directed and random byte streams into the hasher, with random idle
// cycles on both sides, a long hold-off on the digest side and a drain pause
// on the byte side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  import sha1bsh_pkg::*;

  localparam int ItemTarget = 400;
  localparam int MinMessages = 12;
  localparam int HoldCycles = 800;
  localparam int TailCycles = 300;
  localparam int CycleLimit = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        full;
  logic        empty;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        too_long;

  int fail_count;
  int pending;
  int words_checked;

  int  cycle_count = 0;
  int  full_cycles = 0;
  int  n_items = 0;
  int  n_noise = 0;
  int  n_bytes = 0;
  int  n_msgs = 0;
  int  words_taken = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  tx_calm;
  bit  rx_calm;

  sha1_byte_stream_hasher_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (end_of_message),
    .empty            (empty),
    .pop              (pop),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word),
    .too_long_o       (too_long)
  );

  sha1_digest_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (end_of_message),
    .empty            (empty),
    .pop              (pop),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word),
    .too_long_o       (too_long),
    .fail_count       (fail_count),
    .pending          (pending),
    .words_checked    (words_checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  assign tx_calm = (n_items >= 150) && (n_items < 260);
  assign rx_calm = (words_taken >= 45) && (words_taken < 80);

  always @(posedge clk_i) begin
    cycle_count++;
    if (push && full) begin
      full_cycles++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d digest words outstanding",
               cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The digest side pops at random and once holds off long enough to back
  // the block up into its byte input.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        words_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && words_taken >= 40) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        pop <= rx_calm || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    while (!tx_calm && $urandom_range(99) < 6) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (hb || eom) begin
      n_items++;
    end else begin
      n_noise++;
    end
    if (hb) begin
      n_bytes++;
    end
    if (eom) begin
      n_msgs++;
    end
  endtask

  task automatic send_message(input int len);
    bit bare_end;
    bare_end = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  function automatic int pick_length();
    int r;
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    r = $urandom_range(99);
    if (r < 80) begin
      return $urandom_range(12);
    end else if (r < 93) begin
      return edges[$urandom_range(9)];
    end
    return $urandom_range(140, 65);
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, one-byte messages at both byte extremes, a message with
    // an ignored item inside, a bare end marker after bytes, and an empty
    // message right after an ignored item.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    while (n_items < ItemTarget || n_msgs < MinMessages) begin
      send_message(pick_length());
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d messages from %0d counted items (%0d bytes) plus %0d ignored items.",
             n_msgs, n_items, n_bytes, n_noise);
    $display("Compared %0d digest words; byte input stalled for %0d cycles.",
             words_checked, full_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sha1_byte_stream_hasher_unit.f =====
hw/rtl/sha1bsh_pkg.sv
hw/rtl/sha1bsh_front.sv
hw/rtl/sha1bsh_core.sv
hw/rtl/sha1bsh_out.sv
hw/rtl/sha1_byte_stream_hasher_unit.sv
dv/sha1_digest_checker.sv
dv/tb_top.sv
